// ----- sv/rgb_to_hsv_convert_core_defines.svh -----
// Assertion macros for the RGB to HSV converter.
// Included by the top level; needs no other file.
`ifndef RGB_TO_HSV_CONVERT_CORE_DEFINES_SVH
`define RGB_TO_HSV_CONVERT_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define RHC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("rhc assertion failed");
`define RHC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("rhc assertion failed");
`else
`define RHC_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define RHC_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ----- sv/rhc_pkg.sv -----
// Shared widths, constants and the item type passed from front to back.
// No dependencies.
package rhc_pkg;
	localparam int CH_W        = 8;
	localparam int HUE_W       = 16;
	localparam int DEN_W       = 9;   // 2*delta or 2*max, up to 510
	localparam int HNUM_W      = 22;  // 12000*|diff| + delta, below 2^22
	localparam int SNUM_W      = 17;  // 510*delta + max, below 2^17
	localparam int QUOT_W      = 13;  // hue fraction up to 6000
	localparam int QUEUE_DEPTH = 2;

	localparam logic [HNUM_W-1:0] HUE_TWO_SECTOR = HNUM_W'(12000);
	localparam logic [SNUM_W-1:0] SAT_SCALE      = SNUM_W'(510);
	localparam logic [HUE_W-1:0]  HUE_OFF_RED    = HUE_W'(0);
	localparam logic [HUE_W-1:0]  HUE_OFF_GREEN  = HUE_W'(12000);
	localparam logic [HUE_W-1:0]  HUE_OFF_BLUE   = HUE_W'(24000);
	localparam logic [HUE_W-1:0]  HUE_OFF_TURN   = HUE_W'(36000);

	typedef struct packed {
		logic [HNUM_W-1:0] hue_num;
		logic [DEN_W-1:0]  hue_den;
		logic [HUE_W-1:0]  hue_off;
		logic              hue_neg;
		logic [SNUM_W-1:0] sat_num;
		logic [DEN_W-1:0]  sat_den;
		logic              undef;
		logic [CH_W-1:0]   value;
	} rhc_item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} rhc_q_stat_t;
endpackage

// ----- sv/rhc_front.sv -----
// Front end: finds max/min and sector, forms dividends and divisors.
// Depends on rhc_pkg.
module rhc_front (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [rhc_pkg::CH_W-1:0] red,
	input  logic [rhc_pkg::CH_W-1:0] green,
	input  logic [rhc_pkg::CH_W-1:0] blue,
	output logic                    out_valid,
	input  logic                    out_ready,
	output rhc_pkg::rhc_item_t      out_item
);
	import rhc_pkg::*;

	localparam logic [1:0] SEC_RED   = 2'd0;
	localparam logic [1:0] SEC_GREEN = 2'd1;
	localparam logic [1:0] SEC_BLUE  = 2'd2;

	logic [1:0]      sector;
	logic [CH_W-1:0] mx, mn, d, a;
	logic [CH_W:0]   diff, ndiff;
	logic            neg;
	rhc_item_t       item;
	logic            valid_s1;
	rhc_item_t       item_s1;

	always_comb begin
		if (red >= green && red >= blue) begin
			sector = SEC_RED;
		end else if (green >= blue) begin
			sector = SEC_GREEN;
		end else begin
			sector = SEC_BLUE;
		end
		mn = (red <= green) ? red : green;
		mn = (mn <= blue) ? mn : blue;
		case (sector)
			SEC_RED: begin
				mx   = red;
				diff = {1'b0, green} - {1'b0, blue};
			end
			SEC_GREEN: begin
				mx   = green;
				diff = {1'b0, blue} - {1'b0, red};
			end
			default: begin
				mx   = blue;
				diff = {1'b0, red} - {1'b0, green};
			end
		endcase
		d     = mx - mn;
		ndiff = -diff;
		neg   = diff[CH_W];
		a     = neg ? ndiff[CH_W-1:0] : diff[CH_W-1:0];
		case (sector)
			SEC_RED:   item.hue_off = neg ? HUE_OFF_TURN : HUE_OFF_RED;
			SEC_GREEN: item.hue_off = HUE_OFF_GREEN;
			default:   item.hue_off = HUE_OFF_BLUE;
		endcase
		// negative side rounds via off - floor((12000a + d - 1) / 2d)
		item.hue_num = HNUM_W'(a) * HUE_TWO_SECTOR + HNUM_W'(d) - HNUM_W'(neg);
		item.hue_den = {d, 1'b0};
		item.hue_neg = neg;
		item.sat_num = SNUM_W'(d) * SAT_SCALE + SNUM_W'(mx);
		item.sat_den = {mx, 1'b0};
		item.undef   = (d == '0);
		item.value   = mx;
	end

	assign in_ready  = !valid_s1 || out_ready;
	assign out_valid = valid_s1;
	assign out_item  = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= item;
		end
	end
endmodule

// ----- sv/rhc_queue.sv -----
// Short queue between front and back so each side stalls on its own.
// Depends on rhc_pkg.
module rhc_queue #(
	parameter int DEPTH = rhc_pkg::QUEUE_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  rhc_pkg::rhc_item_t  push_item,
	input  logic                pop,
	output rhc_pkg::rhc_item_t  head_item,
	output rhc_pkg::rhc_q_stat_t stat
);
	import rhc_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL = CW'(DEPTH);

	rhc_item_t     mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] cnt_q;

	assign stat.full  = (cnt_q == FULL);
	assign stat.empty = (cnt_q == '0);
	assign head_item  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end
endmodule

// ----- sv/rhc_back.sv -----
// Back end: pipelined restoring dividers (one quotient bit per stage) for hue
// and saturation, then the sector offset and the output register. Uses rhc_pkg.
module rhc_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  rhc_pkg::rhc_item_t in_item,
	output logic               pop,
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [31:0]        m_tdata,  // hue_centideg[15:0], saturation[23:16], value[31:24]
	output logic [0:0]         m_tuser   // hue_undefined[0]
);
	import rhc_pkg::*;

	localparam int RW = DEN_W;

	function automatic logic [RW:0] div_step(input logic [RW-1:0] rem, input logic b,
		input logic [DEN_W-1:0] den);
		logic [RW:0] t;
		logic [RW:0] s;
		t = {rem, b};
		s = t - {1'b0, den};
		if (t >= {1'b0, den}) begin
			return {1'b1, s[RW-1:0]};
		end else begin
			return {1'b0, t[RW-1:0]};
		end
	endfunction

	logic              en;
	logic              vld_s  [QUOT_W];
	rhc_item_t         item_s [QUOT_W];
	logic [RW-1:0]     hrem_s [QUOT_W];
	logic [RW-1:0]     srem_s [QUOT_W];
	logic [QUOT_W-1:0] hq_s   [QUOT_W];
	logic [QUOT_W-1:0] sq_s   [QUOT_W];

	logic              out_vld_q;
	logic [HUE_W-1:0]  hue_q;
	logic [CH_W-1:0]   sat_q, val_q;
	logic              undef_q;

	// whole pipeline moves together; a bubble at the output frees it
	assign en  = !out_vld_q || m_tready;
	assign pop = en && in_valid;

	genvar k;
	generate
		for (k = 0; k < QUOT_W; k++) begin : g_stage
			logic [RW:0]       hs, ss;
			rhc_item_t         it;
			logic [RW-1:0]     hr, sr;
			logic [QUOT_W-1:0] hq, sq;
			logic              v;

			if (k == 0) begin : g_first
				// top dividend bits are below the divisor as the quotient fits QUOT_W
				assign it = in_item;
				assign v  = in_valid;
				assign hr = RW'(in_item.hue_num >> QUOT_W);
				assign sr = RW'(in_item.sat_num >> QUOT_W);
				assign hq = '0;
				assign sq = '0;
			end else begin : g_next
				assign it = item_s[k-1];
				assign v  = vld_s[k-1];
				assign hr = hrem_s[k-1];
				assign sr = srem_s[k-1];
				assign hq = hq_s[k-1];
				assign sq = sq_s[k-1];
			end

			assign hs = div_step(hr, it.hue_num[QUOT_W-1-k], it.hue_den);
			assign ss = div_step(sr, it.sat_num[QUOT_W-1-k], it.sat_den);

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					vld_s[k] <= 1'b0;
				end else if (en) begin
					vld_s[k] <= v;
				end
			end

			always_ff @(posedge clk) begin
				if (en) begin
					item_s[k] <= it;
					hrem_s[k] <= hs[RW-1:0];
					srem_s[k] <= ss[RW-1:0];
					hq_s[k]   <= {hq[QUOT_W-2:0], hs[RW]};
					sq_s[k]   <= {sq[QUOT_W-2:0], ss[RW]};
				end
			end
		end
	endgenerate

	logic [HUE_W-1:0] hue_frac, hue_nx;
	rhc_item_t        last;

	always_comb begin
		last     = item_s[QUOT_W-1];
		hue_frac = HUE_W'(hq_s[QUOT_W-1]);
		hue_nx   = last.hue_neg ? last.hue_off - hue_frac : last.hue_off + hue_frac;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (en) begin
			out_vld_q <= vld_s[QUOT_W-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hue_q   <= last.undef ? '0 : hue_nx;
			sat_q   <= last.undef ? '0 : sq_s[QUOT_W-1][CH_W-1:0];
			val_q   <= last.value;
			undef_q <= last.undef;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {val_q, sat_q, hue_q};
	assign m_tuser  = undef_q;
endmodule

// ----- sv/rgb_to_hsv_convert_core.sv -----
// RGB to HSV converter: one pixel per clock sustained while the output accepts.
// From input transfer to output valid a pixel passes the front register (which loads
// on the transfer edge), a queue entry, 13 divider stages of one quotient bit each
// and the output register. Stalls on the output freeze the back end while the front
// keeps filling the queue.
// arst_n clears all valid flags and queue pointers; data registers are not reset.
`include "rgb_to_hsv_convert_core_defines.svh"
module rgb_to_hsv_convert_core #(
	parameter int QUEUE_DEPTH = rhc_pkg::QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // red[7:0], green[15:8], blue[23:16]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // hue_centideg[15:0], saturation[23:16], value[31:24]
	output logic [0:0]  m_tuser    // hue_undefined[0]
);
	import rhc_pkg::*;

	logic        f_valid, q_push, q_pop;
	rhc_item_t   f_item, q_head;
	rhc_q_stat_t q_stat;

	rhc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.red      (s_tdata[7:0]),
		.green    (s_tdata[15:8]),
		.blue     (s_tdata[23:16]),
		.out_valid(f_valid),
		.out_ready(!q_stat.full),
		.out_item (f_item)
	);

	assign q_push = f_valid && !q_stat.full;

	rhc_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_item(f_item),
		.pop      (q_pop),
		.head_item(q_head),
		.stat     (q_stat)
	);

	rhc_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(!q_stat.empty),
		.in_item (q_head),
		.pop     (q_pop),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

	// gray pixels carry no hue and no saturation
	`RHC_ASSERT_IMP(a_gray_zero, clk, arst_n, m_tvalid && m_tuser[0], m_tdata[23:0] == 24'd0)
	`RHC_ASSERT_IMP(a_hue_range, clk, arst_n, m_tvalid, m_tdata[15:0] < 16'd36000)
	`RHC_ASSERT_IMP(a_coloured_nonzero, clk, arst_n, m_tvalid && !m_tuser[0],
		m_tdata[31:24] != 8'd0 && m_tdata[23:16] != 8'd0)
	// a full queue stays full until the back end takes an entry
	`RHC_ASSERT_NXT(a_queue_hold, clk, arst_n, q_stat.full && !q_pop, q_stat.full)
endmodule

// ----- tb/sv/tb_rgb_to_hsv_convert_core.sv -----
// Self-checking testbench for rgb_to_hsv_convert_core: drives pixels on the input stream
// and checks every HSV result against an integer predictor held in a small scoreboard.
// Needs only the RTL (rhc_pkg, the front, queue and back modules, and the core).
module tb_rgb_to_hsv_convert_core;

	typedef struct {
		bit [15:0] hue;
		bit        undef;
		bit [7:0]  sat;
		bit [7:0]  value;
	} hsv_pixel_t;

	class hsv_scoreboard;
		hsv_pixel_t hsv_due[$];
		int errors;

		function new();
			errors = 0;
		endfunction

		// exact integer hue/saturation, quotients rounded half up
		function hsv_pixel_t hsv_of(bit [7:0] r, bit [7:0] g, bit [7:0] b);
			hsv_pixel_t px;
			int ri, gi, bi, mx, mn, d, num;
			ri = r;
			gi = g;
			bi = b;
			mx = (ri > gi) ? ri : gi;
			mx = (mx > bi) ? mx : bi;
			mn = (ri < gi) ? ri : gi;
			mn = (mn < bi) ? mn : bi;
			d = mx - mn;
			px.value = mx[7:0];
			if (d == 0) begin
				px.undef = 1'b1;
				px.hue = '0;
				px.sat = '0;
			end else begin
				px.undef = 1'b0;
				px.sat = 8'((510 * d + mx) / (2 * mx));
				if (ri == mx) begin
					num = 6000 * (gi - bi);
				end else if (gi == mx) begin
					num = 6000 * (bi - ri) + 12000 * d;
				end else begin
					num = 6000 * (ri - gi) + 24000 * d;
				end
				if (num < 0)
					num = num + 36000 * d;
				num = (2 * num + d) / (2 * d);
				if (num >= 36000)
					num = num - 36000;
				px.hue = 16'(num);
			end
			return px;
		endfunction

		function void note_pixel(bit [7:0] r, bit [7:0] g, bit [7:0] b);
			hsv_due.push_back(hsv_of(r, g, b));
		endfunction

		function void flag(string what);
			errors++;
			if (errors <= 10)
				$display("[%0t] MISMATCH %s", $time, what);
		endfunction

		function void check_result(logic [31:0] data, logic [0:0] user);
			hsv_pixel_t exp_px;
			if (hsv_due.size() == 0) begin
				flag($sformatf("unexpected result tdata=%h tuser=%b", data, user));
				return;
			end
			exp_px = hsv_due.pop_front();
			if (data[15:0] !== exp_px.hue || user[0] !== exp_px.undef ||
			    data[23:16] !== exp_px.sat || data[31:24] !== exp_px.value)
				flag($sformatf({"exp hue=%0d undef=%0d sat=%0d val=%0d ",
					"got hue=%0d undef=%b sat=%0d val=%0d"},
					exp_px.hue, exp_px.undef, exp_px.sat, exp_px.value,
					data[15:0], user[0], data[23:16], data[31:24]));
		endfunction

		function int pending();
			return hsv_due.size();
		endfunction
	endclass

	localparam int RESET_CYCLES = 7;
	localparam int HOLD_CYCLES  = 300;
	localparam int TAIL_CYCLES  = 40;
	localparam int RANDOM_ITEMS = 930;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [23:0] s_tdata;   // red[7:0], green[15:8], blue[23:16]
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;   // hue_centideg[15:0], saturation[23:16], value[31:24]
	logic [0:0]  m_tuser;   // hue_undefined[0]

	int tx_idle_pct;
	int rx_idle_pct;
	logic hold_go;

	hsv_scoreboard sb = new();

	rgb_to_hsv_convert_core DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	// directed pixels, 24'hRRGGBB
	bit [23:0] directed_px [] = '{
		24'h000000, 24'hffffff, 24'h808080, 24'h010101,
		24'hff0000, 24'h00ff00, 24'h0000ff,
		24'hffff00, 24'h00ffff, 24'hff00ff,
		24'hc8c80a, 24'h0ac8c8, 24'hc80ac8,
		24'hff0001, 24'h010000, 24'hfffefe,
		24'h020101, 24'h200100, 24'h01ff00,
		24'h000100, 24'h7f80ff, 24'hff8040
	};

	task automatic send_pixel(bit [7:0] r, bit [7:0] g, bit [7:0] b);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {b, g, r};
		do
			@(posedge clk);
		while (!s_tready);
		sb.note_pixel(r, g, b);
	endtask

	task automatic send_random_pixel();
		bit [7:0] r, g, b, base, lo;
		r = 8'($urandom);
		g = 8'($urandom);
		b = 8'($urandom);
		case ($urandom_range(9))
			0: begin  // gray
				g = r;
				b = r;
			end
			1: begin  // two channels tied at the maximum
				base = 8'($urandom_range(255, 1));
				lo = 8'($urandom_range(base - 1));
				case ($urandom_range(2))
					0: begin r = base; g = base; b = lo; end
					1: begin r = lo; g = base; b = base; end
					default: begin r = base; g = lo; b = base; end
				endcase
			end
			2, 3: begin  // small spread, fine hue steps
				base = 8'($urandom_range(250));
				r = base + 8'($urandom_range(5));
				g = base + 8'($urandom_range(5));
				b = base + 8'($urandom_range(5));
			end
			4: begin  // channels at the rails
				r = $urandom_range(1) ? 8'hff : 8'h00;
				g = $urandom_range(1) ? 8'hff : 8'($urandom);
				b = $urandom_range(1) ? 8'h00 : 8'($urandom);
			end
			default: ;
		endcase
		send_pixel(r, g, b);
	endtask

	// result side: checks each transfer, then decides tready for the next edge
	int hold_left = 0;
	bit hold_taken = 0;
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tdata, m_tuser);
		if (hold_go && !hold_taken) begin
			hold_taken = 1;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	initial begin
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		hold_go <= 1'b0;
		tx_idle_pct <= 14;
		rx_idle_pct <= 59;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_px[i])
			send_pixel(directed_px[i][23:16], directed_px[i][15:8], directed_px[i][7:0]);

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == RANDOM_ITEMS / 3) begin
				tx_idle_pct <= 59;
				rx_idle_pct <= 14;
			end else if (n == 2 * RANDOM_ITEMS / 3) begin
				// no idling; long output stall so the pipe backs up into the input
				tx_idle_pct <= 0;
				rx_idle_pct <= 0;
				hold_go <= 1'b1;
			end
			send_random_pixel();
		end
		s_tvalid <= 1'b0;

		while (sb.pending() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("tb_rgb_to_hsv_convert_core: done, clean");
		end else begin
			$display("tb_rgb_to_hsv_convert_core: done, errors");
		end
		$finish;
	end

	initial begin
		#(4 * 200000);
		$display("tb_rgb_to_hsv_convert_core: done, errors");
		$finish;
	end

endmodule

// ----- rgb_to_hsv_convert_core.f -----
+incdir+sv
sv/rhc_pkg.sv
sv/rhc_front.sv
sv/rhc_queue.sv
sv/rhc_back.sv
sv/rgb_to_hsv_convert_core.sv
tb/sv/tb_rgb_to_hsv_convert_core.sv
